>>> rtl/sbsm_pkg.sv
// ----------------------------------------------------------------------------
// sbsm_pkg
// Shared types and constants for the serial bank switch mapper: access and
// target codes, register select codes, control defaults and field widths.
// ----------------------------------------------------------------------------
package sbsm_pkg;

    // field widths
    localparam int ACTION_W      = 2;
    localparam int ADDR_W        = 16;
    localparam int DATA_W        = 8;
    localparam int TARGET_W      = 3;
    localparam int ROM_ADDR_W    = 18;
    localparam int CFG_INDEX_W   = 1;
    localparam int CFG_DATA_W    = 5;
    localparam int S_TDATA_W     = 24;
    localparam int M_TDATA_W     = 32;

    // memory sizes
    localparam int PRG_RAM_BYTES_DEF = 4096;
    localparam int PRG_WINDOW_BYTES  = 8192;
    localparam int PRG_WINDOW_W      = 13;
    localparam int CHR_RAM_BYTES     = 8192;
    localparam int CHR_RAM_AW        = 13;

    // bus access kinds
    typedef enum logic [ACTION_W-1:0] {
        ACT_CPU_READ  = 2'd0,
        ACT_CPU_WRITE = 2'd1,
        ACT_PPU_READ  = 2'd2,
        ACT_PPU_WRITE = 2'd3
    } action_t;

    // where an access landed
    typedef enum logic [TARGET_W-1:0] {
        TGT_NONE    = 3'd0,
        TGT_PRG_RAM = 3'd1,
        TGT_PRG_ROM = 3'd2,
        TGT_CHR_ROM = 3'd3,
        TGT_CHR_RAM = 3'd4
    } target_t;

    // internal register chosen by address bits 14:13 on a completed load
    typedef enum logic [1:0] {
        SEL_CONTROL  = 2'd0,
        SEL_CHR_LOW  = 2'd1,
        SEL_CHR_HIGH = 2'd2,
        SEL_PRG      = 2'd3
    } reg_sel_t;

    // program banking modes from control bits 3:2
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_ROM_BANKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHR_USES_RAM  = 1'b1;

    // reset and clear values
    localparam logic [4:0] CONTROL_RESET    = 5'h0C;
    localparam logic [4:0] CONTROL_FIX_LAST = 5'h0C;
    localparam logic [4:0] PRG_BANKS_RESET  = 5'd2;
    localparam logic [2:0] LOAD_LAST_COUNT  = 3'd4;
    localparam logic [2:0] PRG_RAM_AREA     = 3'b011;

    // one access after decode, waiting on the RAM read
    typedef struct packed {
        target_t                 target;
        logic [ROM_ADDR_W-1:0]   rom_address;
        logic                    loaded;
        logic                    prg_rd;
        logic                    chr_rd;
    } stage_t;

endpackage

>>> rtl/sbsm_ram.sv
// ----------------------------------------------------------------------------
// sbsm_ram
// Generic single-port synchronous RAM with a registered read that holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module sbsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/serial_bank_switch_mapper_top.sv
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_top
// Cartridge bank mapper: serial register load, program and graphics address
// translation, program RAM and graphics RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one CPU or PPU bus access per transaction; s_tuser
//   gives the access kind. m_ channel returns exactly one result per access,
//   in order: s_tuser-like target code on m_tuser and the read byte,
//   translated ROM offset and load-complete flag on m_tdata.
//   Configuration (ROM bank count, graphics RAM select) is written on the
//   cfg_ port while no access is in flight.
// Throughput and pipeline:
//   one access per cycle while the output is not stalled. Decode, register
//   update and the RAM access are issued in the accept cycle; the RAM read
//   lands in the RAM output register as the access enters the decode stage,
//   which then moves to the output register that drives m_tvalid.
//   Both RAMs are single port with registered read.
// Reset and stall:
//   aresetn clears the mapper registers (control to fixed-last-bank mode)
//   and both pipeline stages. RAM contents are not cleared. When m_tready
//   is low the output register holds and one more access is still taken
//   into the decode stage before s_tready drops.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_top #(
    parameter int PRG_RAM_BYTES = sbsm_pkg::PRG_RAM_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration writes
    input  logic                              cfg_wr_en,
    input  logic [sbsm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [sbsm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // access channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [sbsm_pkg::S_TDATA_W-1:0]    s_tdata,  // address[15:0], write_data[23:16]
    input  logic [sbsm_pkg::ACTION_W-1:0]     s_tuser,  // action[1:0]
    // result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [sbsm_pkg::M_TDATA_W-1:0]    m_tdata,  // read_data[7:0], rom_address[25:8],
                                                        // register_loaded[26], zero[31:27]
    output logic [sbsm_pkg::TARGET_W-1:0]     m_tuser   // target[2:0]
);
    import sbsm_pkg::*;

    localparam int PRG_AW         = $clog2(PRG_RAM_BYTES);
    localparam int PRG_FOLD_STEPS = (PRG_WINDOW_BYTES - 1) / PRG_RAM_BYTES;

    // configuration registers
    logic [4:0] prg_rom_banks_reg;
    logic       chr_uses_ram_reg;

    // mapper registers
    logic [4:0] shift_value_reg, shift_value_next;
    logic [2:0] shift_count_reg, shift_count_next;
    logic [4:0] control_reg,     control_next;
    logic [4:0] chr_low_reg,     chr_low_next;
    logic [4:0] chr_high_reg,    chr_high_next;
    logic [3:0] prg_bank_reg,    prg_bank_next;

    // pipeline
    logic                 s1_valid_reg, s1_valid_next;
    stage_t               s1_reg, s1_next;
    logic                 out_valid_reg, out_valid_next;
    target_t              out_target_reg;
    logic [ROM_ADDR_W-1:0] out_rom_addr_reg;
    logic                 out_loaded_reg;
    logic [DATA_W-1:0]    out_rdata_reg;
    logic                 accept;
    logic                 out_load;

    // RAM ports
    logic                  prg_we, prg_re;
    logic [PRG_AW-1:0]     prg_addr;
    logic [DATA_W-1:0]     prg_dout;
    logic                  chr_we, chr_re;
    logic [CHR_RAM_AW-1:0] chr_addr;
    logic [DATA_W-1:0]     chr_dout;

    // decoded access fields
    action_t               act;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_W-1:0]     wdata;

    assign act   = action_t'(s_tuser);
    assign addr  = s_tdata[ADDR_W-1:0];
    assign wdata = s_tdata[ADDR_W +: DATA_W];

    // handshake: decode stage moves on when the output register frees up
    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || out_load;
    assign accept   = s_tvalid && s_tready;

    // configuration port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prg_rom_banks_reg <= PRG_BANKS_RESET;
            chr_uses_ram_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PRG_ROM_BANKS: prg_rom_banks_reg <= cfg_wdata;
                CFG_CHR_USES_RAM:  chr_uses_ram_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // access decode, serial load and translation
    always_comb begin
        logic [1:0]              prg_mode;
        logic [3:0]              last_bank;
        logic [3:0]              prg_sel_bank;
        logic [ROM_ADDR_W-1:0]   prg_rom;
        logic [16:0]             chr_off;
        logic [PRG_WINDOW_W-1:0] prg_off;
        logic [4:0]              load_value;

        shift_value_next = shift_value_reg;
        shift_count_next = shift_count_reg;
        control_next     = control_reg;
        chr_low_next     = chr_low_reg;
        chr_high_next    = chr_high_reg;
        prg_bank_next    = prg_bank_reg;

        s1_next          = '0;
        s1_next.target   = TGT_NONE;
        prg_we = 1'b0;
        prg_re = 1'b0;
        chr_we = 1'b0;
        chr_re = 1'b0;

        // program ROM translation
        prg_mode  = control_reg[3:2];
        last_bank = (prg_rom_banks_reg == 5'd0) ? 4'd0 : 4'(prg_rom_banks_reg - 5'd1);
        if (addr[14]) begin
            prg_sel_bank = (prg_mode == PRG_MODE_FIX_FIRST) ? prg_bank_reg : last_bank;
        end else begin
            prg_sel_bank = (prg_mode == PRG_MODE_FIX_FIRST) ? 4'd0 : prg_bank_reg;
        end
        if (prg_mode == PRG_MODE_FIX_FIRST || prg_mode == PRG_MODE_FIX_LAST) begin
            prg_rom = {prg_sel_bank, addr[13:0]};
        end else begin
            prg_rom = {prg_bank_reg[3:1], addr[14:0]};
        end

        // graphics translation: 8KB or two 4KB banks
        if (control_reg[4]) begin
            chr_off = {(addr[12] ? chr_high_reg : chr_low_reg), addr[11:0]};
        end else begin
            chr_off = {chr_low_reg[4:1], addr[12:0]};
        end

        // program RAM mirror fold
        prg_off = addr[PRG_WINDOW_W-1:0];
        for (int k = 0; k < PRG_FOLD_STEPS; k++) begin
            if ({1'b0, prg_off} >= (PRG_WINDOW_W+1)'(PRG_RAM_BYTES)) begin
                prg_off = PRG_WINDOW_W'({1'b0, prg_off} - (PRG_WINDOW_W+1)'(PRG_RAM_BYTES));
            end
        end
        prg_addr = prg_off[PRG_AW-1:0];
        chr_addr = chr_off[CHR_RAM_AW-1:0];

        load_value = {wdata[0], shift_value_reg[4:1]};

        if (accept) begin
            case (act)
                ACT_CPU_READ, ACT_CPU_WRITE: begin
                    if (addr[15]) begin
                        if (act == ACT_CPU_READ) begin
                            s1_next.target      = TGT_PRG_ROM;
                            s1_next.rom_address = prg_rom;
                        end else if (wdata[7]) begin
                            // clear write resets the load and fixes the last bank
                            shift_value_next = '0;
                            shift_count_next = '0;
                            control_next     = control_reg | CONTROL_FIX_LAST;
                        end else if (shift_count_reg == LOAD_LAST_COUNT) begin
                            // fifth bit completes the load
                            shift_value_next = '0;
                            shift_count_next = '0;
                            s1_next.loaded   = 1'b1;
                            unique case (reg_sel_t'(addr[14:13]))
                                SEL_CONTROL:  control_next  = load_value;
                                SEL_CHR_LOW:  chr_low_next  = load_value;
                                SEL_CHR_HIGH: chr_high_next = load_value;
                                SEL_PRG:      prg_bank_next = load_value[3:0];
                                default: ;
                            endcase
                        end else begin
                            shift_value_next = load_value;
                            shift_count_next = shift_count_reg + 3'd1;
                        end
                    end else if (addr[15:13] == PRG_RAM_AREA) begin
                        s1_next.target = TGT_PRG_RAM;
                        if (act == ACT_CPU_READ) begin
                            prg_re         = 1'b1;
                            s1_next.prg_rd = 1'b1;
                        end else begin
                            prg_we = 1'b1;
                        end
                    end
                end
                default: begin
                    // ppu side, pattern area only
                    if (!addr[13]) begin
                        if (chr_uses_ram_reg) begin
                            s1_next.target = TGT_CHR_RAM;
                            if (act == ACT_PPU_READ) begin
                                chr_re         = 1'b1;
                                s1_next.chr_rd = 1'b1;
                            end else begin
                                chr_we = 1'b1;
                            end
                        end else if (act == ACT_PPU_READ) begin
                            s1_next.target      = TGT_CHR_ROM;
                            s1_next.rom_address = ROM_ADDR_W'(chr_off);
                        end
                    end
                end
            endcase
        end
    end

    // mapper register update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_value_reg <= '0;
            shift_count_reg <= '0;
            control_reg     <= CONTROL_RESET;
            chr_low_reg     <= '0;
            chr_high_reg    <= '0;
            prg_bank_reg    <= '0;
        end else begin
            shift_value_reg <= shift_value_next;
            shift_count_reg <= shift_count_next;
            control_reg     <= control_next;
            chr_low_reg     <= chr_low_next;
            chr_high_reg    <= chr_high_next;
            prg_bank_reg    <= prg_bank_next;
        end
    end

    // pipeline valid control
    always_comb begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (out_load) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end

        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
        if (out_load) begin
            out_target_reg   <= s1_reg.target;
            out_rom_addr_reg <= s1_reg.rom_address;
            out_loaded_reg   <= s1_reg.loaded;
            if (s1_reg.prg_rd) begin
                out_rdata_reg <= prg_dout;
            end else if (s1_reg.chr_rd) begin
                out_rdata_reg <= chr_dout;
            end else begin
                out_rdata_reg <= '0;
            end
        end
    end

    // memories
    sbsm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (PRG_RAM_BYTES)
    ) u_prg_ram (
        .aclk  (aclk),
        .we    (prg_we),
        .re    (prg_re),
        .addr  (prg_addr),
        .wdata (wdata),
        .rdata (prg_dout)
    );

    sbsm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CHR_RAM_BYTES)
    ) u_chr_ram (
        .aclk  (aclk),
        .we    (chr_we),
        .re    (chr_re),
        .addr  (chr_addr),
        .wdata (wdata),
        .rdata (chr_dout)
    );

    // result channel
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_target_reg;
    assign m_tdata  = {(M_TDATA_W - DATA_W - ROM_ADDR_W - 1)'(0), out_loaded_reg,
                       out_rom_addr_reg, out_rdata_reg};

    // load counter never reaches five
    a_shift_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        shift_count_reg <= LOAD_LAST_COUNT)
        else $error("shift count out of range");

    // a completed load never reports a memory target
    a_loaded_no_target: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_loaded_reg |-> out_target_reg == TGT_NONE)
        else $error("register load with memory target");

    // rom offsets only for rom targets
    a_rom_addr_target: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_rom_addr_reg != '0 |->
            out_target_reg == TGT_PRG_ROM || out_target_reg == TGT_CHR_ROM)
        else $error("rom offset on non-rom target");

    // read data only from a ram target
    a_rdata_target: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_rdata_reg != '0 |->
            out_target_reg == TGT_PRG_RAM || out_target_reg == TGT_CHR_RAM)
        else $error("read data on non-ram target");

    // decode stage handed over lands in the output register
    a_stage_handover: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> out_valid_reg)
        else $error("decode stage result lost");

    // at most one memory read pending per item
    a_single_read: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> !(s1_reg.prg_rd && s1_reg.chr_rd))
        else $error("two memory reads for one access");

endmodule
